/* hw/rtl/h2r_pkg.sv */
// Shared types and constants for the HSV to RGB converter.
package h2r_pkg;

    localparam int HUE_W  = 9;
    localparam int FRAC_W = 6;
    localparam int SV_W   = 9;
    localparam int CHAN_W = 8;
    // Term weight 256 * 60 before the saturation product is taken off
    localparam int X_W    = 14;
    localparam int PROD_W = SV_W + X_W;
    // 255 / (256 * 256 * 60) reduces to 17 / 2^18
    localparam int SCALE_SHIFT = 18;
    localparam int SCALED_W    = PROD_W + 5;

    localparam logic [FRAC_W-1:0] SECTOR_DEG = FRAC_W'(60);
    localparam logic [X_W-1:0]    FULL_X     = X_W'(15360);
    localparam logic [CHAN_W-1:0] CHAN_MAX   = CHAN_W'(255);
    localparam logic [HUE_W-1:0]  HUE_WRAP   = HUE_W'(360);

    typedef enum logic [2:0] {
        SEC_0,
        SEC_1,
        SEC_2,
        SEC_3,
        SEC_4,
        SEC_5,
        SEC_BLACK
    } sector_t;

    // First stage output: decoded hue plus operands
    typedef struct packed {
        logic              valid;
        sector_t           sector;
        logic [FRAC_W-1:0] frac;
        logic [SV_W-1:0]   sat;
        logic [SV_W-1:0]   val;
    } hue_stage_t;

endpackage

/* hw/rtl/h2r_sector_stage.sv */
// First pipeline stage: split the hue into sector and offset within it.
module h2r_sector_stage
    import h2r_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [HUE_W-1:0] hue,
    input  logic [SV_W-1:0]  sat,
    input  logic [SV_W-1:0]  val,
    output hue_stage_t       stage
);

    sector_t          sector_next;
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] offset;
    hue_stage_t       stage_reg;
    hue_stage_t       stage_next;

    // Find the sector by comparing against the sector bounds
    always_comb
    begin
        priority if (hue < HUE_W'(60))
        begin
            sector_next = SEC_0;
            base        = HUE_W'(0);
        end
        else if (hue < HUE_W'(120))
        begin
            sector_next = SEC_1;
            base        = HUE_W'(60);
        end
        else if (hue < HUE_W'(180))
        begin
            sector_next = SEC_2;
            base        = HUE_W'(120);
        end
        else if (hue < HUE_W'(240))
        begin
            sector_next = SEC_3;
            base        = HUE_W'(180);
        end
        else if (hue < HUE_W'(300))
        begin
            sector_next = SEC_4;
            base        = HUE_W'(240);
        end
        else if (hue < HUE_W'(360))
        begin
            sector_next = SEC_5;
            base        = HUE_W'(300);
        end
        else if (hue == HUE_WRAP)
        begin
            sector_next = SEC_0;
            base        = HUE_WRAP;
        end
        else
        begin
            sector_next = SEC_BLACK;
            base        = HUE_WRAP;
        end
    end

    assign offset = hue - base;

    // Gray case: zero saturation makes all terms equal, so any real sector works
    always_comb
    begin
        stage_next.valid  = in_valid;
        stage_next.sector = (sat == '0) ? SEC_0 : sector_next;
        stage_next.frac   = offset[FRAC_W-1:0];
        stage_next.sat    = sat;
        stage_next.val    = val;
    end

    // Clear the stage under reset, then advance it every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

/* hw/rtl/h2r_term_lane.sv */
// Three-stage lane computing one channel term floor(17 * v * x / 2^18).
module h2r_term_lane
    import h2r_pkg::*;
(
    input  logic              clk,
    input  logic [SV_W-1:0]   sat,
    input  logic [FRAC_W-1:0] weight,
    input  logic [SV_W-1:0]   val,
    output logic [CHAN_W-1:0] chan
);

    localparam int SK_W = SV_W + FRAC_W;

    logic [SK_W-1:0]     sk;
    logic [X_W-1:0]      x_next;
    logic [X_W-1:0]      x_reg;
    logic [SV_W-1:0]     val_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-SCALE_SHIFT-1:0] quot;
    logic [CHAN_W-1:0]   chan_next;
    logic [CHAN_W-1:0]   chan_reg;

    // Take the saturation share off full scale, clamp at zero
    assign sk     = SK_W'(sat) * SK_W'(weight);
    assign x_next = (sk >= SK_W'(FULL_X)) ? '0 : (FULL_X - sk[X_W-1:0]);

    // Scale by brightness
    assign prod_next = PROD_W'(val_reg) * PROD_W'(x_reg);

    // Multiply by 17 as shift-add, drop the fraction, saturate
    assign scaled    = (SCALED_W'(prod_reg) << 4) + SCALED_W'(prod_reg);
    assign quot      = scaled[SCALED_W-1:SCALE_SHIFT];
    assign chan_next = (quot > (SCALED_W-SCALE_SHIFT)'(CHAN_MAX))
                       ? CHAN_MAX : quot[CHAN_W-1:0];

    // Advance the lane stages
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        val_reg  <= val;
        prod_reg <= prod_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

/* hw/rtl/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB converter: pipeline control and channel select.
//
// Usage:
//   Drive hue_deg, saturation and brightness with start high for one cycle to
//   issue a transaction. busy is always low: the pipeline takes a new pixel
//   on every clock edge, so start may stay high for back-to-back pixels.
//   Each transaction yields one result on red, green and blue, marked by a
//   one-cycle done pulse; done and the three channels are registered together.
//   Results come out in issue order, one per cycle at full rate.
//   Stages: hue sector decode; saturation product and clamp; brightness
//   product; scale by 255 and saturate; channel select by sector.
//   Throughput is one pixel per cycle through the five register stages above,
//   with the four term lanes running in parallel.
//   The receiver cannot stall, so no backpressure path exists; results must
//   be captured on the cycle done is high.
//   Asynchronous reset (rst_n low) clears all valid bits; pixels in flight
//   are dropped and no done pulse follows until new input is taken.
module hsv_to_rgb_converter
    import h2r_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [HUE_W-1:0]  hue_deg,
    input  logic [SV_W-1:0]   saturation,
    input  logic [SV_W-1:0]   brightness,
    output logic              done,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue
);

    localparam int LANE_DEPTH = 3;

    hue_stage_t        s1;
    logic [FRAC_W-1:0] k_cc;
    logic [CHAN_W-1:0] t_top;
    logic [CHAN_W-1:0] t_aa;
    logic [CHAN_W-1:0] t_bb;
    logic [CHAN_W-1:0] t_cc;

    logic    vld_pipe_reg [LANE_DEPTH];
    sector_t sec_pipe_reg [LANE_DEPTH];

    logic              done_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;

    assign busy = 1'b0;

    h2r_sector_stage u_sector (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .hue      (hue_deg),
        .sat      (saturation),
        .val      (brightness),
        .stage    (s1)
    );

    assign k_cc = SECTOR_DEG - s1.frac;

    h2r_term_lane u_top (
        .clk (clk), .sat (s1.sat), .weight ('0), .val (s1.val), .chan (t_top)
    );

    h2r_term_lane u_aa (
        .clk (clk), .sat (s1.sat), .weight (SECTOR_DEG), .val (s1.val), .chan (t_aa)
    );

    h2r_term_lane u_bb (
        .clk (clk), .sat (s1.sat), .weight (s1.frac), .val (s1.val), .chan (t_bb)
    );

    h2r_term_lane u_cc (
        .clk (clk), .sat (s1.sat), .weight (k_cc), .val (s1.val), .chan (t_cc)
    );

    // Carry valid bits alongside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_DEPTH; i++)
            begin
                vld_pipe_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_pipe_reg[0] <= s1.valid;
            for (int i = 1; i < LANE_DEPTH; i++)
            begin
                vld_pipe_reg[i] <= vld_pipe_reg[i-1];
            end
            done_reg <= vld_pipe_reg[LANE_DEPTH-1];
        end
    end

    // Carry the sector alongside the lanes
    always_ff @(posedge clk)
    begin
        sec_pipe_reg[0] <= s1.sector;
        for (int i = 1; i < LANE_DEPTH; i++)
        begin
            sec_pipe_reg[i] <= sec_pipe_reg[i-1];
        end
    end

    // Route the terms to the channels by sector
    always_comb
    begin
        unique case (sec_pipe_reg[LANE_DEPTH-1])
            SEC_0:
            begin
                red_next = t_top; green_next = t_cc;  blue_next = t_aa;
            end
            SEC_1:
            begin
                red_next = t_bb;  green_next = t_top; blue_next = t_aa;
            end
            SEC_2:
            begin
                red_next = t_aa;  green_next = t_top; blue_next = t_cc;
            end
            SEC_3:
            begin
                red_next = t_aa;  green_next = t_bb;  blue_next = t_top;
            end
            SEC_4:
            begin
                red_next = t_cc;  green_next = t_aa;  blue_next = t_top;
            end
            SEC_5:
            begin
                red_next = t_top; green_next = t_aa;  blue_next = t_bb;
            end
            default:
            begin
                red_next = '0;    green_next = '0;    blue_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

/* test/hsv_to_rgb_checker.sv */
// Checker that predicts every converted pixel and compares it with the block's result.
module hsv_to_rgb_checker
    import h2r_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [HUE_W-1:0]  hue_deg,
    input  logic [SV_W-1:0]   saturation,
    input  logic [SV_W-1:0]   brightness,
    input  logic              done,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    output int                mismatch_count,
    output int                pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // 1.0 in the saturation and brightness fixed point
    localparam longint UNITY = 256;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SV_W-1:0]   sat;
        logic [SV_W-1:0]   val;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } pixel_t;

    pixel_t expected_pixels[$];

    // One channel level: floor(255 * v * (15360 - s*k) / (256*256*60)), clamped
    function automatic logic [CHAN_W-1:0] term_level(longint v, longint s, longint k);
        longint weight;
        longint level;
        weight = longint'(FULL_X) - s * k;
        if (weight <= 0 || v == 0)
            return '0;
        level = (longint'(CHAN_MAX) * v * weight) / (longint'(FULL_X) * UNITY);
        if (level > longint'(CHAN_MAX))
            level = longint'(CHAN_MAX);
        return CHAN_W'(level);
    endfunction

    // Convert one hue, saturation, brightness triple to the expected color
    function automatic pixel_t predict_rgb(logic [HUE_W-1:0] h, logic [SV_W-1:0] s,
                                           logic [SV_W-1:0] v);
        pixel_t            px;
        longint            hue;
        longint            frac;
        longint            sec_num;
        logic [CHAN_W-1:0] top;
        logic [CHAN_W-1:0] aa;
        logic [CHAN_W-1:0] bb;
        logic [CHAN_W-1:0] cc;
        sector_t           sec;
        px.hue = h;
        px.sat = s;
        px.val = v;
        // Gray at the brightness level, whatever the hue
        if (s == '0)
        begin
            px.r = term_level(longint'(v), 0, 0);
            px.g = px.r;
            px.b = px.r;
            return px;
        end
        hue     = (h == HUE_WRAP) ? 0 : longint'(h);
        sec_num = hue / longint'(SECTOR_DEG);
        frac    = hue % longint'(SECTOR_DEG);
        top     = term_level(longint'(v), longint'(s), 0);
        aa      = term_level(longint'(v), longint'(s), longint'(SECTOR_DEG));
        bb      = term_level(longint'(v), longint'(s), frac);
        cc      = term_level(longint'(v), longint'(s), longint'(SECTOR_DEG) - frac);
        sec     = (sec_num > 5) ? SEC_BLACK : sector_t'(sec_num);
        case (sec)
            SEC_0:   begin px.r = top; px.g = cc;  px.b = aa;  end
            SEC_1:   begin px.r = bb;  px.g = top; px.b = aa;  end
            SEC_2:   begin px.r = aa;  px.g = top; px.b = cc;  end
            SEC_3:   begin px.r = aa;  px.g = bb;  px.b = top; end
            SEC_4:   begin px.r = cc;  px.g = aa;  px.b = top; end
            SEC_5:   begin px.r = top; px.g = aa;  px.b = bb;  end
            default: begin px.r = '0;  px.g = '0;  px.b = '0;  end
        endcase
        return px;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_channel(string name, logic [CHAN_W-1:0] got,
                                 logic [CHAN_W-1:0] want, pixel_t px);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d (hue %0d sat %0d val %0d)",
                                      name, got, want, px.hue, px.sat, px.val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t px;
        if (!rst_n)
        begin
            expected_pixels.delete();
            mismatch_count = 0;
            pixels_pending = 0;
        end
        else
        begin
            // Compare each result with the oldest expectation
            if (done === 1'b1)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("result %0d/%0d/%0d with no transaction waiting",
                                              red, green, blue));
                else
                begin
                    px = expected_pixels.pop_front();
                    check_channel("red", red, px.r, px);
                    check_channel("green", green, px.g, px);
                    check_channel("blue", blue, px.b, px);
                end
            end
            // Predict each accepted transaction
            if (start === 1'b1 && busy === 1'b0)
                expected_pixels.push_back(predict_rgb(hue_deg, saturation, brightness));
            pixels_pending = expected_pixels.size();
        end
    end

endmodule

/* test/testbench.sv */
// Top of the HSV to RGB converter test: clock, reset, stimulus and verdict.
module testbench
    import h2r_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1800;
    localparam int TAIL_ITEMS   = 300;
    localparam int CYCLE_LIMIT  = 200000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [HUE_W-1:0]  hue_deg;
    logic [SV_W-1:0]   saturation;
    logic [SV_W-1:0]   brightness;
    logic              done;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    int                mismatch_count;
    int                pixels_pending;
    int                cycle_count = 0;

    hsv_to_rgb_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue_deg    (hue_deg),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsv_to_rgb_checker pixel_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .hue_deg        (hue_deg),
        .saturation     (saturation),
        .brightness     (brightness),
        .done           (done),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .mismatch_count (mismatch_count),
        .pixels_pending (pixels_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    // Drive one transaction and hold it until the block takes it
    task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [SV_W-1:0] s,
                              input logic [SV_W-1:0] v);
        @(negedge clk);
        start      <= 1'b1;
        hue_deg    <= h;
        saturation <= s;
        brightness <= v;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // Drop start for a burst of idle cycles
    task automatic idle_burst(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // Hold off until every expected result has come back
    task automatic drain_pipeline();
        @(negedge clk);
        start <= 1'b0;
        while (pixels_pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [SV_W-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0:       return SV_W'(0);
            1:       return SV_W'(1);
            2:       return SV_W'(255);
            3:       return SV_W'(256);
            4:       return SV_W'(257);
            5:       return SV_W'(511);
            default: return SV_W'($urandom_range(0, 511));
        endcase
    endfunction

    // Mostly in-range pixels, plus full-range noise, gray and sector edges
    task automatic random_pixel();
        int               mode;
        logic [HUE_W-1:0] h;
        logic [SV_W-1:0]  s;
        logic [SV_W-1:0]  v;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
        begin
            h = HUE_W'($urandom_range(0, 360));
            s = SV_W'($urandom_range(1, 256));
            v = SV_W'($urandom_range(0, 256));
        end
        else if (mode == 6)
        begin
            h = HUE_W'($urandom_range(0, 511));
            s = SV_W'($urandom_range(0, 511));
            v = SV_W'($urandom_range(0, 511));
        end
        else if (mode == 7)
        begin
            h = HUE_W'($urandom_range(0, 511));
            s = '0;
            v = SV_W'($urandom_range(0, 511));
        end
        else
        begin
            h = HUE_W'(60 * $urandom_range(0, 7) + ($urandom_range(0, 1) ? 59 : 0));
            s = pick_extreme();
            v = pick_extreme();
        end
        send_pixel(h, s, v);
    endtask

    initial
    begin
        int n;
        rst_n      = 1'b0;
        start      = 1'b0;
        hue_deg    = '0;
        saturation = '0;
        brightness = '0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;

        // Sector starts and ends, wrap, black hues, gray, clamps and saturation
        send_pixel(0, 256, 256);
        send_pixel(59, 256, 256);
        send_pixel(60, 256, 256);
        send_pixel(119, 200, 256);
        send_pixel(120, 256, 200);
        send_pixel(179, 128, 256);
        send_pixel(180, 256, 256);
        send_pixel(240, 256, 128);
        send_pixel(299, 100, 256);
        send_pixel(300, 256, 256);
        send_pixel(359, 256, 256);
        send_pixel(360, 256, 256);
        send_pixel(361, 256, 256);
        send_pixel(420, 128, 200);
        send_pixel(511, 511, 511);
        send_pixel(400, 0, 200);
        send_pixel(90, 0, 256);
        send_pixel(30, 511, 256);
        send_pixel(200, 300, 511);
        send_pixel(45, 128, 511);
        send_pixel(150, 256, 0);
        send_pixel(10, 1, 1);
        send_pixel(0, 0, 0);
        send_pixel(330, 256, 1);
        drain_pipeline();

        // Random transactions; the last stretch runs at full rate
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain_pipeline();
            if (n < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 3) == 0)
                idle_burst($urandom_range(1, 11));
            random_pixel();
        end

        drain_pipeline();
        repeat (12)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
